// ===== sv/pmst_pkg.sv =====
// Shared types and constants for the dense Prim spanning tree engine.
package pmst_pkg;

    localparam int MAX_VERTICES_DEF = 32;
    localparam int VERTEX_W = 5;
    localparam int WEIGHT_W = 14;
    localparam int COST_W = 19;
    localparam int COUNT_W = 6;

    localparam logic [WEIGHT_W-1:0] NO_EDGE = 14'd9999;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_ADD = 2'd1;
    localparam logic [1:0] CMD_RUN = 2'd2;

    localparam logic [1:0] STAT_EDGE = 2'd0;
    localparam logic [1:0] STAT_SINGLE = 2'd1;
    localparam logic [1:0] STAT_DISCONNECTED = 2'd2;

    typedef struct packed {
        logic [1:0]          command;
        logic [VERTEX_W-1:0] end_a;
        logic [VERTEX_W-1:0] end_b;
        logic [WEIGHT_W-1:0] edge_weight;
    } item_t;

    typedef struct packed {
        logic [VERTEX_W-1:0] parent_vertex;
        logic [VERTEX_W-1:0] child_vertex;
        logic [WEIGHT_W-1:0] tree_weight;
        logic [COST_W-1:0]   total_cost;
        logic [1:0]          status;
        logic                last;
    } result_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD_A,
        ST_ADD_B,
        ST_RELAX,
        ST_PICK
    } state_t;

endpackage

// ===== sv/pmst_ifs.sv =====
// Handshake channel interfaces for items, results and configuration writes.
interface pmst_item_if;
    import pmst_pkg::*;
    logic  valid;
    logic  ready;
    item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pmst_result_if;
    import pmst_pkg::*;
    logic    valid;
    logic    ready;
    result_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pmst_cfg_if;
    logic       valid;
    logic       ready;
    logic [5:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== sv/prim_minimum_spanning_tree.sv =====
// Dense Prim minimum spanning tree engine: weight store, relaxation sweep and result register.
//
// Usage: the items channel carries commands. Clear sets every entry of the
// weight store to no-edge, add lowers the two mirrored entries of an edge to
// its weight, and run builds a spanning tree from vertex 0 over the first
// vertex_count vertices. Clear and add give no result; a run gives one
// result per tree edge, ending with a disconnected result when no edge
// reaches the tree, or one single-vertex result for a lone vertex, and
// marks its final result with last. The cfg channel is always ready and
// writes vertex_count.
// Steps: an add is a read, then two read-modify-write steps on the single
// store port; a clear writes one store entry per cycle; a run sweeps each
// tree edge as n-1 store reads, a return of the last read, a close and a pick.
// Reset clears control state and starts a clearing pass over every store
// entry during which no item is taken; configuration writes are still taken.
// Results sit in an output register; while the receiver stalls, the run
// waits in its pick step with the store untouched, and new items are not
// taken until the run has finished and its final result has left the
// output register.
module prim_minimum_spanning_tree
    #(parameter int MAX_VERTICES = pmst_pkg::MAX_VERTICES_DEF)
    (input logic clk,
     input logic rst_n,
     pmst_item_if.sink items,
     pmst_result_if.source results,
     pmst_cfg_if.sink cfg);

    import pmst_pkg::*;

    // Only the first 32 vertices can be named by a five-bit endpoint.
    localparam int LIMIT = (MAX_VERTICES < 32) ? MAX_VERTICES : 32;
    localparam int VW = (LIMIT > 1) ? $clog2(LIMIT) : 1;
    localparam int DEPTH = LIMIT * LIMIT;
    localparam int AW = $clog2(DEPTH);
    localparam logic [COUNT_W-1:0] LIMIT_C = COUNT_W'(LIMIT);

    state_t state_reg, state_next;

    // Weight store, one synchronous port pair.
    logic [WEIGHT_W-1:0] store_mem [DEPTH];
    logic                we;
    logic [AW-1:0]       waddr, raddr;
    logic [WEIGHT_W-1:0] wdata, rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_mem[waddr] <= wdata;
        end
        rdata_reg <= store_mem[raddr];
    end

    function automatic logic [AW-1:0] addr_of(input logic [VW-1:0] r, input logic [VW-1:0] c);
        return AW'(AW'(r) * AW'(LIMIT) + AW'(c));
    endfunction

    logic [COUNT_W-1:0] vcount_reg;
    logic [COUNT_W-1:0] n_reg, n_next;
    logic [AW-1:0]      clr_reg, clr_next;
    item_t              item_reg, item_next;

    // Tree state, one entry per vertex.
    logic [LIMIT-1:0]    in_tree_reg, in_tree_next;
    logic [WEIGHT_W-1:0] bd_reg [LIMIT];
    logic [VW-1:0]       bp_reg [LIMIT];
    logic                init_run;
    logic                upd;

    logic [VW-1:0]       pick_reg, pick_next;
    logic [VW-1:0]       ri_reg, ri_next;
    logic                issuing_reg, issuing_next;
    logic                rv_reg, rv_next;
    logic [VW-1:0]       rix_reg, rix_next;
    logic [WEIGHT_W-1:0] low_reg, low_next;
    logic [VW-1:0]       lowix_reg, lowix_next;
    logic [COST_W-1:0]   cost_reg, cost_next;
    logic [COUNT_W-1:0]  edges_reg, edges_next;

    logic    out_valid_reg, out_valid_next;
    result_t out_reg, out_next;
    logic    out_free;

    logic [WEIGHT_W-1:0] cand;
    logic [COST_W-1:0]   cost_sum;

    assign cfg.ready = 1'b1;
    assign results.valid = out_valid_reg;
    assign results.data = out_reg;
    assign out_free = !out_valid_reg || results.ready;
    // A single-vertex run loads the output register at once, so items wait
    // for it to be free.
    assign items.ready = (state_reg == ST_IDLE) && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= COUNT_W'(1);
        end
        else if (cfg.valid)
        begin
            vcount_reg <= cfg.data;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        n_next = n_reg;
        clr_next = clr_reg;
        item_next = item_reg;
        in_tree_next = in_tree_reg;
        pick_next = pick_reg;
        ri_next = ri_reg;
        issuing_next = issuing_reg;
        rv_next = 1'b0;
        rix_next = ri_reg;
        low_next = low_reg;
        lowix_next = lowix_reg;
        cost_next = cost_reg;
        edges_next = edges_reg;
        out_valid_next = out_valid_reg && !results.ready;
        out_next = out_reg;
        init_run = 1'b0;
        upd = 1'b0;
        we = 1'b0;
        waddr = clr_reg;
        wdata = NO_EDGE;
        raddr = addr_of(VW'(items.data.end_a), VW'(items.data.end_b));
        cand = (rdata_reg < bd_reg[rix_reg]) ? rdata_reg : bd_reg[rix_reg];
        cost_sum = cost_reg + COST_W'(low_reg);

        unique case (state_reg)
            ST_CLEAR:
            begin
                we = 1'b1;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (items.valid && out_free)
                begin
                    item_next = items.data;
                    unique case (items.data.command)
                        CMD_CLEAR:
                        begin
                            clr_next = '0;
                            state_next = ST_CLEAR;
                        end
                        CMD_ADD:
                        begin
                            if (items.data.end_a != items.data.end_b
                                && COUNT_W'(items.data.end_a) < LIMIT_C
                                && COUNT_W'(items.data.end_b) < LIMIT_C)
                            begin
                                state_next = ST_ADD_A;
                            end
                        end
                        CMD_RUN:
                        begin
                            init_run = 1'b1;
                            in_tree_next = LIMIT'(1);
                            cost_next = '0;
                            edges_next = '0;
                            pick_next = '0;
                            if (vcount_reg == '0)
                            begin
                                n_next = COUNT_W'(1);
                            end
                            else if (vcount_reg > LIMIT_C)
                            begin
                                n_next = LIMIT_C;
                            end
                            else
                            begin
                                n_next = vcount_reg;
                            end
                            if (n_next == COUNT_W'(1))
                            begin
                                // Single vertex: one flagged result.
                                out_valid_next = 1'b1;
                                out_next = '{parent_vertex: '0, child_vertex: '0,
                                             tree_weight: '0, total_cost: '0,
                                             status: STAT_SINGLE, last: 1'b1};
                            end
                            else
                            begin
                                ri_next = VW'(1);
                                issuing_next = 1'b1;
                                low_next = NO_EDGE;
                                lowix_next = '0;
                                state_next = ST_RELAX;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_ADD_A:
            begin
                waddr = addr_of(VW'(item_reg.end_a), VW'(item_reg.end_b));
                wdata = item_reg.edge_weight;
                we = item_reg.edge_weight < rdata_reg;
                raddr = addr_of(VW'(item_reg.end_b), VW'(item_reg.end_a));
                state_next = ST_ADD_B;
            end
            ST_ADD_B:
            begin
                waddr = addr_of(VW'(item_reg.end_b), VW'(item_reg.end_a));
                wdata = item_reg.edge_weight;
                we = item_reg.edge_weight < rdata_reg;
                state_next = ST_IDLE;
            end
            ST_RELAX:
            begin
                raddr = addr_of(pick_reg, ri_reg);
                if (issuing_reg)
                begin
                    rv_next = 1'b1;
                    rix_next = ri_reg;
                    ri_next = ri_reg + VW'(1);
                    if (COUNT_W'(ri_reg) == n_reg - COUNT_W'(1))
                    begin
                        issuing_next = 1'b0;
                    end
                end
                if (rv_reg && !in_tree_reg[rix_reg])
                begin
                    upd = rdata_reg < bd_reg[rix_reg];
                    if (cand < low_reg)
                    begin
                        low_next = cand;
                        lowix_next = rix_reg;
                    end
                end
                if (!issuing_reg && !rv_reg)
                begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (low_reg == NO_EDGE)
                    begin
                        out_next = '{parent_vertex: '0, child_vertex: '0,
                                     tree_weight: '0, total_cost: cost_reg,
                                     status: STAT_DISCONNECTED, last: 1'b1};
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        in_tree_next[lowix_reg] = 1'b1;
                        cost_next = cost_sum;
                        edges_next = edges_reg + COUNT_W'(1);
                        out_next.parent_vertex = VERTEX_W'(bp_reg[lowix_reg]);
                        out_next.child_vertex = VERTEX_W'(lowix_reg);
                        out_next.tree_weight = low_reg;
                        out_next.total_cost = cost_sum;
                        out_next.status = STAT_EDGE;
                        out_next.last = (edges_reg + COUNT_W'(2) == n_reg);
                        pick_next = lowix_reg;
                        if (out_next.last)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            ri_next = VW'(1);
                            issuing_next = 1'b1;
                            low_next = NO_EDGE;
                            lowix_next = '0;
                            state_next = ST_RELAX;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg <= '0;
            out_valid_reg <= 1'b0;
            issuing_reg <= 1'b0;
            rv_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            out_valid_reg <= out_valid_next;
            issuing_reg <= issuing_next;
            rv_reg <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg <= n_next;
        item_reg <= item_next;
        in_tree_reg <= in_tree_next;
        pick_reg <= pick_next;
        ri_reg <= ri_next;
        rix_reg <= rix_next;
        low_reg <= low_next;
        lowix_reg <= lowix_next;
        cost_reg <= cost_next;
        edges_reg <= edges_next;
        out_reg <= out_next;
    end

    // Distance and parent entries: bulk set at run start, at most one update per
    // relaxation step otherwise.
    always_ff @(posedge clk)
    begin
        if (init_run)
        begin
            for (int k = 0; k < LIMIT; k++)
            begin
                bd_reg[k] <= NO_EDGE;
                bp_reg[k] <= '0;
            end
        end
        else if (upd)
        begin
            bd_reg[rix_reg] <= rdata_reg;
            bp_reg[rix_reg] <= pick_reg;
        end
    end

endmodule
